### src/ebft_pkg.sv
// shared types, constants and helpers for the escaped bus frame transmitter
// no dependencies

package ebft_pkg;

  localparam logic [7:0] ESC_BYTE   = 8'h10;
  localparam logic [7:0] START_BYTE = 8'h81;
  localparam logic [7:0] SPECIAL_A  = 8'h80;
  localparam logic [7:0] SUB_A      = 8'hC0;
  localparam logic [7:0] SUB_B      = 8'hC1;
  localparam logic [7:0] SUB_ESC    = 8'hC2;
  localparam logic [7:0] IDLE_TAIL  = 8'hFF;

  localparam logic [1:0] ACT_IDLE    = 2'd0;
  localparam logic [1:0] ACT_HEADER  = 2'd1;
  localparam logic [1:0] ACT_PAYLOAD = 2'd2;

  // logical bytes in one job (before escaping)
  localparam int unsigned JOB_SLOTS       = 4;
  localparam int unsigned EBFT_JOBQ_DEPTH = 2;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] dest_addr;
    logic [7:0] frame_length;
    logic [7:0] payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       frame_end;
    logic       run_end;
  } out_item_t;

  // one job: up to four logical bytes, each may need escaping
  typedef struct packed {
    logic [2:0]                     cnt;
    logic [JOB_SLOTS-1:0][7:0]      syms;
    logic [JOB_SLOTS-1:0]           esc;
    logic                           fe_last;
  } job_t;

  function automatic logic needs_esc(input logic [7:0] b);
    return (b == SPECIAL_A) || (b == START_BYTE) || (b == ESC_BYTE);
  endfunction

  function automatic logic [7:0] esc_sub(input logic [7:0] b);
    logic [7:0] s;
    s = b;
    if (b == SPECIAL_A) begin
      s = SUB_A;
    end else if (b == START_BYTE) begin
      s = SUB_B;
    end else if (b == ESC_BYTE) begin
      s = SUB_ESC;
    end
    return s;
  endfunction

endpackage

### src/ebft_front.sv
// front part: accepts items, keeps frame state, turns each item into a job
// depends on ebft_pkg

module ebft_front
  import ebft_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  output logic     job_push_o,
  output job_t     job_o
);

  logic       in_frame_q, in_frame_d;
  logic [7:0] left_q, left_d;
  logic [7:0] sum_q, sum_d;

  logic [7:0] hdr_sum, pay_sum, left_dec;

  assign hdr_sum  = item_i.dest_addr + item_i.frame_length;
  assign pay_sum  = sum_q + item_i.payload_byte;
  assign left_dec = left_q - 8'd1;

  always_comb begin
    in_frame_d = in_frame_q;
    left_d     = left_q;
    sum_d      = sum_q;
    job_push_o = 1'b0;
    job_o      = '0;
    if (accept_i) begin
      case (item_i.action)
        ACT_IDLE: begin
          in_frame_d    = 1'b0;
          left_d        = '0;
          sum_d         = '0;
          job_push_o    = 1'b1;
          job_o.cnt     = 3'd4;
          job_o.syms[0] = START_BYTE;
          job_o.syms[1] = 8'h00;
          job_o.syms[2] = 8'h00;
          job_o.syms[3] = IDLE_TAIL;
          job_o.esc     = '0;
          job_o.fe_last = 1'b1;
        end
        ACT_HEADER: begin
          sum_d         = hdr_sum;
          left_d        = item_i.frame_length;
          job_push_o    = 1'b1;
          job_o.syms[0] = START_BYTE;
          job_o.syms[1] = item_i.dest_addr;
          job_o.syms[2] = item_i.frame_length;
          job_o.syms[3] = ~hdr_sum;
          job_o.esc     = 4'b1110;
          if (item_i.frame_length == 8'd0) begin
            // empty frame: checksum follows the length at once
            in_frame_d    = 1'b0;
            job_o.cnt     = 3'd4;
            job_o.fe_last = 1'b1;
          end else begin
            in_frame_d    = 1'b1;
            job_o.cnt     = 3'd3;
            job_o.fe_last = 1'b0;
          end
        end
        ACT_PAYLOAD: begin
          if (in_frame_q) begin
            sum_d         = pay_sum;
            left_d        = left_dec;
            job_push_o    = 1'b1;
            job_o.syms[0] = item_i.payload_byte;
            job_o.syms[1] = ~pay_sum;
            job_o.esc     = 4'b0011;
            if (left_dec == 8'd0) begin
              in_frame_d    = 1'b0;
              job_o.cnt     = 3'd2;
              job_o.fe_last = 1'b1;
            end else begin
              job_o.cnt     = 3'd1;
              job_o.fe_last = 1'b0;
            end
          end
        end
        default: begin
          job_push_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      left_q     <= '0;
      sum_q      <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      left_q     <= left_d;
      sum_q      <= sum_d;
    end
  end

endmodule

### src/ebft_queue.sv
// short job queue between the front and back parts
// depends on ebft_pkg

module ebft_queue
  import ebft_pkg::*;
#(
  parameter int unsigned Depth = EBFT_JOBQ_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  input  logic pop_i,
  output job_t data_o,
  output logic full_o,
  output logic valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

### src/ebft_back.sv
// back part: expands jobs into escaped bus bytes, one per cycle when not held by pop, into an output register
// depends on ebft_pkg

module ebft_back
  import ebft_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      job_pop_o,
  input  logic      pop_i,
  output logic      empty_o,
  output out_item_t out_o
);

  logic [1:0] idx_q, idx_d;
  logic       pfx_q, pfx_d;
  logic       vld_q, vld_d;
  out_item_t  out_q, out_d;

  logic [7:0] sym;
  logic       esc_now, is_last, load;

  assign sym     = job_i.syms[idx_q];
  assign esc_now = job_i.esc[idx_q] && needs_esc(sym) && !pfx_q;
  assign is_last = ({1'b0, idx_q} == (job_i.cnt - 3'd1));
  assign load    = job_valid_i && (!vld_q || pop_i);

  always_comb begin
    idx_d     = idx_q;
    pfx_d     = pfx_q;
    vld_d     = vld_q && !pop_i;
    out_d     = out_q;
    job_pop_o = 1'b0;
    if (load) begin
      vld_d = 1'b1;
      if (esc_now) begin
        // prefix byte, substitute follows next
        out_d.bus_byte  = ESC_BYTE;
        out_d.frame_end = 1'b0;
        out_d.run_end   = 1'b0;
        pfx_d           = 1'b1;
      end else begin
        out_d.bus_byte  = job_i.esc[idx_q] ? esc_sub(sym) : sym;
        out_d.frame_end = is_last && job_i.fe_last;
        out_d.run_end   = is_last;
        pfx_d           = 1'b0;
        if (is_last) begin
          idx_d     = '0;
          job_pop_o = 1'b1;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      pfx_q <= 1'b0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      pfx_q <= pfx_d;
      vld_q <= vld_d;
    end
  end

  assign empty_o = !vld_q;
  assign out_o   = out_q;

endmodule

### src/escaped_bus_frame_transmitter.sv
// top level of the escaped bus frame transmitter
// depends on ebft_pkg, ebft_front, ebft_queue, ebft_back
//
// usage:
//  - input side is a queue write port: drive in_data_i and push; the item is
//    taken on a rising edge with push high and full low
//  - result side is a queue read port: while empty is low out_data_o holds
//    the oldest bus byte; pop high on a rising edge takes it
//  - each item yields 0 to 7 bus bytes: idle gives four, a header three to
//    five or four to seven with an empty frame, a payload byte one to four
//  - run_end marks the last byte of an item, frame_end the frame's last byte
//  - an accepted item's job goes into the job queue, and its bytes then pass
//    through the back part's single output register; throughput: one bus
//    byte per cycle while the receiver pops, set by that output register
//  - the job queue holds JobQDepth items, so new items are taken while
//    earlier ones still stream out
//  - reset clears frame state, the job queue and the output valid flag
//  - a stalled receiver holds the output byte; the job queue then fills
//    and full rises until pops resume

module escaped_bus_frame_transmitter
  import ebft_pkg::*;
#(
  parameter int unsigned JobQDepth = EBFT_JOBQ_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data_o
);

  // front -> queue
  logic accept, job_push;
  job_t job_in;

  // queue -> back
  logic job_valid, job_pop;
  job_t job_head;

  assign accept = push && !full;

  // frame state and item classification
  ebft_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_data_i),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  // decouples item intake from byte streaming
  ebft_queue #(
    .Depth (JobQDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .pop_i   (job_pop),
    .data_o  (job_head),
    .full_o  (full),
    .valid_o (job_valid)
  );

  // escaping and byte output
  ebft_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_head),
    .job_pop_o   (job_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_o       (out_data_o)
  );

`ifndef SYNTHESIS
  // frame end is always the last byte of its item
  a_fe_run_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.frame_end) |-> out_data_o.run_end)
    else $error("frame_end without run_end");

  // an item never ends on a bare escape prefix
  a_no_trailing_esc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.run_end) |-> (out_data_o.bus_byte != ESC_BYTE))
    else $error("run ends on escape prefix");

  // an escape prefix is followed by a substitute byte at the next pop
  a_esc_follow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && out_data_o.bus_byte == ESC_BYTE && !out_data_o.run_end)
    |=> (empty || out_data_o.bus_byte == SUB_A || out_data_o.bus_byte == SUB_B ||
         out_data_o.bus_byte == SUB_ESC))
    else $error("escape prefix not followed by substitute");

  // a job is only taken by the back part when the queue holds one
  a_pop_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> job_valid)
    else $error("job pop from empty queue");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// testbench for the escaped bus frame transmitter: directed and random frames
// checked byte by byte against an in-bench frame predictor; needs ebft_pkg and the rtl

module tb_top;
  import ebft_pkg::*;

  // action code that the block has to ignore
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving on either side
  localparam int HOLD_CYCLES    = 150;   // long receiver hold-off for the pressure test
  localparam int DRAIN_CYCLES   = 16;    // quiet tail after the last expected byte
  localparam int MAX_SHOWN      = 10;    // mismatches printed in full

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      push      = 1'b0;
  logic      pop       = 1'b0;
  in_item_t  in_data_i = '0;
  logic      full;
  logic      empty;
  out_item_t out_data_o;

  escaped_bus_frame_transmitter DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // framer state as the predictor sees it
  bit        frame_open  = 1'b0;
  logic [7:0] payload_due = '0;
  logic [7:0] frame_sum   = '0;

  // bus bytes of the item being predicted, then the store of all bytes still due
  out_item_t run_bytes[$];
  out_item_t expected_bytes[$];

  int error_count    = 0;
  int items_sent     = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_req_cnt   = 0;  // bumped by a test to ask for a receiver hold-off
  int hold_ack_cnt   = 0;
  int recv_hold_left = 0;
  int quiet_cycles   = 0;

  // ---------------------------------------------------------------------------
  // frame predictor
  // ---------------------------------------------------------------------------

  function automatic void add_byte(input logic [7:0] b, input logic fe);
    out_item_t r;
    r.bus_byte  = b;
    r.frame_end = fe;
    r.run_end   = 1'b0;
    run_bytes.push_back(r);
  endfunction

  // byte stuffing: the three reserved values go out as escape plus substitute,
  // and only the substitute carries the frame end flag
  function automatic void add_stuffed(input logic [7:0] b, input logic fe);
    case (b)
      SPECIAL_A: begin
        add_byte(ESC_BYTE, 1'b0);
        add_byte(SUB_A, fe);
      end
      START_BYTE: begin
        add_byte(ESC_BYTE, 1'b0);
        add_byte(SUB_B, fe);
      end
      ESC_BYTE: begin
        add_byte(ESC_BYTE, 1'b0);
        add_byte(SUB_ESC, fe);
      end
      default: begin
        add_byte(b, fe);
      end
    endcase
  endfunction

  // one's complement checksum closes the frame
  function automatic void close_frame();
    add_stuffed(~frame_sum, 1'b1);
    frame_open  = 1'b0;
    payload_due = '0;
  endfunction

  function automatic void predict_bus_bytes(input in_item_t it);
    out_item_t last;
    run_bytes.delete();
    case (it.action)
      ACT_IDLE: begin
        // empty bus frame, drops whatever frame was open
        frame_open  = 1'b0;
        payload_due = '0;
        frame_sum   = '0;
        add_byte(START_BYTE, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(IDLE_TAIL, 1'b1);
      end
      ACT_HEADER: begin
        // a new header abandons an open frame without its checksum
        add_byte(START_BYTE, 1'b0);
        add_stuffed(it.dest_addr, 1'b0);
        add_stuffed(it.frame_length, 1'b0);
        frame_sum   = it.dest_addr + it.frame_length;
        payload_due = it.frame_length;
        frame_open  = 1'b1;
        if (it.frame_length == 8'h00) begin
          close_frame();
        end
      end
      ACT_PAYLOAD: begin
        // payload outside a frame is dropped silently
        if (frame_open) begin
          add_stuffed(it.payload_byte, 1'b0);
          frame_sum   = frame_sum + it.payload_byte;
          payload_due = payload_due - 8'd1;
          if (payload_due == 8'h00) begin
            close_frame();
          end
        end
      end
      default: begin
      end
    endcase
    if (run_bytes.size() > 0) begin
      last = run_bytes.pop_back();
      last.run_end = 1'b1;
      run_bytes.push_back(last);
    end
    foreach (run_bytes[i]) begin
      expected_bytes.push_back(run_bytes[i]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random pops, long hold-offs on request, byte check
  // ---------------------------------------------------------------------------

  function automatic void check_bus_byte(input out_item_t got);
    out_item_t want;
    if (expected_bytes.size() == 0) begin
      error_count++;
      if (error_count <= MAX_SHOWN) begin
        $display("%0t: unexpected bus byte %h frame_end %b run_end %b",
                 $realtime, got.bus_byte, got.frame_end, got.run_end);
      end
    end else begin
      want = expected_bytes.pop_front();
      if (got.bus_byte !== want.bus_byte || got.frame_end !== want.frame_end ||
          got.run_end !== want.run_end) begin
        error_count++;
        if (error_count <= MAX_SHOWN) begin
          $display("%0t: mismatch bus_byte %h/%h frame_end %b/%b run_end %b/%b (exp/act)",
                   $realtime, want.bus_byte, got.bus_byte, want.frame_end,
                   got.frame_end, want.run_end, got.run_end);
        end
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      // values sampled here are the ones that stood before the edge
      if (pop && !empty) begin
        check_bus_byte(out_data_o);
      end
      if (hold_req_cnt != hold_ack_cnt) begin
        hold_ack_cnt   <= hold_req_cnt;
        recv_hold_left <= HOLD_CYCLES;
        pop            <= 1'b0;
      end else if (recv_hold_left > 0) begin
        recv_hold_left <= recv_hold_left - 1;
        pop            <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog: ends the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  function automatic in_item_t make_item(input logic [1:0] act, input logic [7:0] dest,
                                         input logic [7:0] len, input logic [7:0] pb);
    in_item_t it;
    it.action       = act;
    it.dest_addr    = dest;
    it.frame_length = len;
    it.payload_byte = pb;
    return it;
  endfunction

  // random byte, leaning toward the values that need stuffing
  function automatic logic [7:0] rand_byte();
    logic [7:0] b;
    case ($urandom_range(7))
      0: b = ESC_BYTE;
      1: b = SPECIAL_A;
      2: b = START_BYTE;
      default: b = 8'($urandom_range(255));
    endcase
    return b;
  endfunction

  // push stays high from one item to the next unless the sender idles,
  // so it is never lowered and raised in the same step
  task automatic send_item(input in_item_t it);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (full) begin
      @(posedge clk_i);
    end
    predict_bus_bytes(it);
    items_sent++;
  endtask

  // mostly well-formed frames with random content, some cut short, some noise
  task automatic send_random_frame();
    int pick;
    int len;
    int count;
    pick = $urandom_range(99);
    if (pick < 8) begin
      len = 0;
    end else if (pick < 80) begin
      len = $urandom_range(8, 1);
    end else if (pick < 94) begin
      len = $urandom_range(40, 9);
    end else begin
      len = $urandom_range(255, 41);
    end
    count = len;
    if (len > 40) begin
      // long frames are always abandoned after a few bytes
      count = $urandom_range(6, 1);
    end else if (len > 0 && $urandom_range(99) < 12) begin
      count = $urandom_range(len - 1, 0);
    end
    send_item(make_item(ACT_HEADER, rand_byte(), len[7:0], rand_byte()));
    repeat (count) begin
      send_item(make_item(ACT_PAYLOAD, rand_byte(), rand_byte(), rand_byte()));
    end
    pick = $urandom_range(99);
    if (pick < 5) begin
      send_item(make_item(ACT_IDLE, rand_byte(), rand_byte(), rand_byte()));
    end else if (pick < 10) begin
      send_item(make_item(ACT_PAYLOAD, rand_byte(), rand_byte(), rand_byte()));
    end else if (pick < 14) begin
      send_item(make_item(ACT_UNUSED, rand_byte(), rand_byte(), rand_byte()));
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes, every action and every corner of the framing rules
  task automatic test_directed_cases();
    send_idle_pct = 31;
    recv_idle_pct = 61;
    // idle frame, stray payload, ignored action with all bits set
    send_item(make_item(ACT_IDLE, 8'hFF, 8'hFF, 8'hFF));
    send_item(make_item(ACT_PAYLOAD, 8'h00, 8'h00, 8'h55));
    send_item(make_item(ACT_UNUSED, 8'hFF, 8'hFF, 8'hFF));
    // zero length headers: plain, checksum needing escape, escaped dest
    send_item(make_item(ACT_HEADER, 8'h00, 8'h00, 8'h00));
    send_item(make_item(ACT_HEADER, 8'h7F, 8'h00, 8'h00));
    send_item(make_item(ACT_HEADER, 8'hEF, 8'h00, 8'h00));
    send_item(make_item(ACT_HEADER, START_BYTE, 8'h00, 8'h00));
    // escaped dest and length, reserved payload values, then abandoned by a header
    send_item(make_item(ACT_HEADER, SPECIAL_A, ESC_BYTE, 8'h00));
    send_item(make_item(ACT_PAYLOAD, 8'h00, 8'h00, START_BYTE));
    send_item(make_item(ACT_PAYLOAD, 8'h00, 8'h00, ESC_BYTE));
    send_item(make_item(ACT_PAYLOAD, 8'h00, 8'h00, SPECIAL_A));
    send_item(make_item(ACT_PAYLOAD, 8'h00, 8'h00, 8'hFF));
    send_item(make_item(ACT_PAYLOAD, 8'h00, 8'h00, 8'h00));
    // one byte frame whose checksum is the escape byte itself
    send_item(make_item(ACT_HEADER, 8'hEE, 8'h01, 8'hFF));
    send_item(make_item(ACT_PAYLOAD, 8'hFF, 8'hFF, 8'h00));
    // frame cut short by an idle item, then payload with no frame open
    send_item(make_item(ACT_HEADER, 8'h01, 8'h03, 8'h00));
    send_item(make_item(ACT_PAYLOAD, 8'h00, 8'h00, 8'hFF));
    send_item(make_item(ACT_PAYLOAD, 8'h00, 8'h00, 8'h7F));
    send_item(make_item(ACT_IDLE, 8'h00, 8'h00, 8'h00));
    send_item(make_item(ACT_PAYLOAD, 8'h00, 8'h00, 8'h33));
    // longest length, ignored action inside a frame, idle closes it
    send_item(make_item(ACT_HEADER, 8'hFF, 8'hFF, 8'h00));
    send_item(make_item(ACT_PAYLOAD, 8'h00, 8'h00, 8'hAA));
    send_item(make_item(ACT_UNUSED, 8'h00, 8'h00, 8'h00));
    send_item(make_item(ACT_PAYLOAD, 8'h00, 8'h00, 8'h01));
    send_item(make_item(ACT_IDLE, 8'hAA, 8'h55, 8'hAA));
  endtask

  task automatic test_random_frames(input int sender_pct, input int receiver_pct,
                                    input int n);
    int target;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    target = items_sent + n;
    while (items_sent < target) begin
      send_random_frame();
    end
  endtask

  // receiver holds off for a long stretch while the sender keeps offering,
  // so the job queue fills and full stalls the input
  task automatic test_backpressure();
    int target;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req_cnt++;
    target = items_sent + 15;
    while (items_sent < target) begin
      send_random_frame();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_frames(31, 61, 50);
    test_random_frames(61, 31, 50);
    test_backpressure();
    test_random_frames(0, 0, 35);
    push <= 1'b0;

    // drain everything still due, then a short quiet tail for stray bytes
    while (expected_bytes.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
src/ebft_pkg.sv
src/ebft_front.sv
src/ebft_queue.sv
src/ebft_back.sv
src/escaped_bus_frame_transmitter.sv
tb/tb_top.sv
